/* design/ilffa_pkg.sv */
// Types and constants shared by the first-fit allocator modules.
// No dependencies.
`timescale 1ns / 1ps
package ilffa_pkg;
    localparam logic [1:0] FUNC_INIT    = 2'd0;
    localparam logic [1:0] FUNC_ALLOC   = 2'd1;
    localparam logic [1:0] FUNC_FREE    = 2'd2;
    localparam logic [1:0] FUNC_REALLOC = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // datapath commands from the controller
    typedef struct packed {
        logic start_walk;  // clear offset and index, issue read of entry 0
        logic step_walk;   // advance past current header, issue next read
        logic do_init;
        logic take_block;  // commit allocation at current index
        logic release_blk; // free block at saved index
        logic save_found;  // remember current index as the located block
    } ilffa_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic walk_end;    // index reached block_count
        logic fits;        // current header free and large enough
        logic addr_hit;    // current payload offset equals addr
        logic hdr_inuse;
        logic found_fits;  // located block already holds req bytes
        logic req_bad;
        logic init_short;
    } ilffa_stat_t;
endpackage

/* design/ilffa_datapath.sv */
// Header store, walk counters and byte totals of the allocator.
// Depends on ilffa_pkg.
`timescale 1ns / 1ps
module ilffa_datapath import ilffa_pkg::*; #(
    parameter int HEAP_BYTES = 4096,
    parameter int ALIGN      = 8,
    parameter int MAX_REQUEST = 4096,
    parameter int DEPTH      = HEAP_BYTES / 8,
    parameter int AW         = $clog2(DEPTH),
    parameter int HW         = $clog2(HEAP_BYTES + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  ilffa_cmd_t    cmd,
    output ilffa_stat_t   stat,
    input  logic [12:0]   heap_len,
    input  logic [12:0]   req_size,
    input  logic [11:0]   addr,
    output logic [11:0]   cur_addr,
    output logic [12:0]   inuse_out,
    output logic [12:0]   used_out
);
    localparam int HB = 8;
    localparam logic [HW-1:0] AMASK = HW'(ALIGN - 1);

    logic [HW-1:0] mem [DEPTH];
    logic [HW-1:0] rd_reg;
    logic [AW:0]   idx_reg, cnt_reg, found_reg;
    logic [HW+1:0] off_reg;
    logic [HW-1:0] used_reg, inuse_reg;
    logic          tail_open_reg;
    logic          tail_pend_reg;
    logic [AW-1:0] tail_wa_reg;
    logic [HW-1:0] tail_wd_reg;

    logic [HW-1:0] sz, needed, hclamp, rem, found_sz_reg;
    logic          we;
    logic [AW-1:0] wa, ra;
    logic [HW-1:0] wd;
    logic          is_last;
    logic          tail_set, tail_wr;

    assign sz      = {rd_reg[HW-1:1], 1'b0};
    assign needed  = (HW'(req_size) + AMASK) & ~AMASK;
    assign hclamp  = (32'(heap_len) > HEAP_BYTES) ? HW'(HEAP_BYTES) : HW'(heap_len);
    assign rem     = sz - needed;
    assign is_last = (idx_reg + 1'b1 == cnt_reg) && tail_open_reg;
    assign tail_set = cmd.take_block && is_last && rem >= HW'(HB) &&
                      cnt_reg < (AW+1)'(DEPTH);

    assign stat.walk_end   = (idx_reg >= cnt_reg);
    assign stat.fits       = !rd_reg[0] && (needed <= sz);
    assign stat.addr_hit   = (off_reg + (HW+2)'(HB)) == (HW+2)'(addr);
    assign stat.hdr_inuse  = rd_reg[0];
    assign stat.found_fits = found_sz_reg >= HW'(req_size);
    assign stat.req_bad    = (req_size == 13'd0) || (32'(req_size) > MAX_REQUEST);
    assign stat.init_short = hclamp < HW'(HB);

    assign cur_addr  = 12'(off_reg + (HW+2)'(HB));
    assign inuse_out = 13'(inuse_reg);
    assign used_out  = 13'(used_reg);

    assign ra = cmd.start_walk ? '0 : AW'(idx_reg + 1'b1);

    always_comb begin
        we = 1'b0; wa = AW'(idx_reg); wd = '0; tail_wr = 1'b0;
        if (cmd.do_init) begin
            we = 1'b1; wa = '0; wd = (hclamp - HW'(HB)) & ~AMASK;
        end else if (cmd.take_block) begin
            we = 1'b1; wd = is_last ? (needed | HW'(1)) : (rd_reg | HW'(1));
        end else if (cmd.release_blk) begin
            we = 1'b1; wa = AW'(found_reg); wd = found_sz_reg;
        end else if (tail_pend_reg) begin
            // new tail header is written from the pending registers once the write port is free
            we = 1'b1; wa = tail_wa_reg; wd = tail_wd_reg; tail_wr = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        if (cmd.start_walk || cmd.step_walk) rd_reg <= mem[ra];
        if (tail_set) begin
            tail_wa_reg <= AW'(cnt_reg);
            tail_wd_reg <= rem - HW'(HB);
        end
        if (cmd.save_found) found_sz_reg <= sz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0; cnt_reg <= '0; found_reg <= '0; off_reg <= '0;
            used_reg <= '0; inuse_reg <= '0; tail_open_reg <= 1'b0;
            tail_pend_reg <= 1'b0;
        end else begin
            if (tail_set) tail_pend_reg <= 1'b1;
            else if (tail_wr) tail_pend_reg <= 1'b0;
            if (cmd.start_walk) begin
                idx_reg <= '0; off_reg <= '0;
            end else if (cmd.step_walk) begin
                idx_reg <= idx_reg + 1'b1;
                off_reg <= off_reg + (HW+2)'(HB) + (HW+2)'(sz);
            end
            if (cmd.save_found) found_reg <= idx_reg;
            if (cmd.do_init) begin
                cnt_reg <= (AW+1)'(1); used_reg <= HW'(HB); inuse_reg <= '0;
                tail_open_reg <= 1'b1;
            end else if (cmd.take_block) begin
                if (is_last) begin
                    inuse_reg <= inuse_reg + needed;
                    if (rem >= HW'(HB) && cnt_reg < (AW+1)'(DEPTH)) begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        used_reg <= used_reg + needed + HW'(HB);
                    end else begin
                        used_reg <= used_reg + needed;
                        tail_open_reg <= 1'b0;
                    end
                end else begin
                    inuse_reg <= inuse_reg + sz;
                end
            end else if (cmd.release_blk) begin
                inuse_reg <= inuse_reg - found_sz_reg;
            end
        end
    end
endmodule

/* design/ilffa_ctrl.sv */
// Sequencer of the allocator: walks headers, decides outcomes, holds the result beat.
// Depends on ilffa_pkg.
`timescale 1ns / 1ps
module ilffa_ctrl import ilffa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [1:0]  func,
    input  logic [11:0] addr,
    input  logic [12:0] req_size,
    input  logic        out_fire,
    input  ilffa_stat_t stat,
    input  logic [11:0] cur_addr,
    output ilffa_cmd_t  cmd,
    output logic        busy,
    output logic        res_valid,
    output logic [1:0]  res_status,
    output logic [11:0] res_addr,
    output logic        res_moved
);
    localparam logic [2:0] S_IDLE = 3'd0, S_DISP = 3'd1, S_FIND = 3'd2,
                           S_ALLOC = 3'd3, S_DONE = 3'd4, S_FREE = 3'd5;
    logic [2:0]  state_reg, state_next;
    logic [1:0]  func_reg, st_reg, st_next;
    logic [11:0] ba_reg, ba_next;
    logic        mv_reg, mv_next, realloc_reg, realloc_next;

    assign busy = state_reg != S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res_status = st_reg;
    assign res_addr = ba_reg;
    assign res_moved = mv_reg;

    always_comb begin
        cmd = '0; state_next = state_reg; st_next = st_reg; ba_next = ba_reg;
        mv_next = mv_reg; realloc_next = realloc_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) begin
                state_next = S_DISP; st_next = ST_OK; ba_next = '0; mv_next = 1'b0;
            end
            S_DISP: begin
                unique case (func_reg)
                    FUNC_INIT: begin
                        if (stat.init_short) st_next = ST_FAIL;
                        else cmd.do_init = 1'b1;
                        state_next = S_DONE;
                    end
                    FUNC_ALLOC: begin
                        realloc_next = 1'b0;
                        if (stat.req_bad) begin
                            st_next = ST_FAIL; state_next = S_DONE;
                        end else begin
                            cmd.start_walk = 1'b1; state_next = S_ALLOC;
                        end
                    end
                    default: begin
                        if (addr == 12'd0) begin
                            if (func_reg == FUNC_FREE) state_next = S_DONE;
                            else if (stat.req_bad) begin
                                st_next = ST_FAIL; state_next = S_DONE;
                            end else begin
                                realloc_next = 1'b0;
                                cmd.start_walk = 1'b1; state_next = S_ALLOC;
                            end
                        end else begin
                            cmd.start_walk = 1'b1; state_next = S_FIND;
                        end
                    end
                endcase
            end
            S_FIND: begin
                if (stat.walk_end) begin
                    st_next = ST_REFUSED; state_next = S_DONE;
                end else if (stat.addr_hit) begin
                    if (!stat.hdr_inuse) begin
                        st_next = ST_REFUSED; state_next = S_DONE;
                    end else begin
                        cmd.save_found = 1'b1; state_next = S_FREE;
                    end
                end else cmd.step_walk = 1'b1;
            end
            S_FREE: begin
                if (func_reg == FUNC_FREE) begin
                    cmd.release_blk = 1'b1; state_next = S_DONE;
                end else if (req_size == 13'd0) begin
                    cmd.release_blk = 1'b1; st_next = ST_FAIL; state_next = S_DONE;
                end else if (stat.found_fits) begin
                    ba_next = addr; state_next = S_DONE;
                end else if (stat.req_bad) begin
                    st_next = ST_FAIL; state_next = S_DONE;
                end else begin
                    realloc_next = 1'b1; cmd.start_walk = 1'b1; state_next = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (stat.walk_end) begin
                    st_next = ST_FAIL; state_next = S_DONE;
                end else if (stat.fits) begin
                    cmd.take_block = 1'b1; ba_next = cur_addr;
                    if (realloc_reg) begin
                        // free old one next cycle (separate write port use)
                        mv_next = 1'b1; state_next = S_FREE;
                        realloc_next = 1'b0;
                    end else state_next = S_DONE;
                end else cmd.step_walk = 1'b1;
            end
            S_DONE: if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        // second S_FREE visit after moved realloc: release old block
        if (state_reg == S_FREE && mv_reg) begin
            cmd = '0; cmd.release_blk = 1'b1; st_next = ST_OK; ba_next = ba_reg;
            state_next = S_DONE; realloc_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; realloc_reg <= 1'b0;
        end else begin
            state_reg <= state_next; realloc_reg <= realloc_next;
        end
    end
    always_ff @(posedge aclk) begin
        if (in_fire && state_reg == S_IDLE) func_reg <= func;
        st_reg <= st_next; ba_reg <= ba_next; mv_reg <= mv_next;
    end
endmodule

/* design/implicit_list_first_fit_allocator.sv */
// First-fit heap allocator over an implicit list of block headers.
// An input beat is taken in S_IDLE and decoded in S_DISP; init and null free then go to
// S_DONE, alloc walks in S_ALLOC, free and realloc walk in S_FIND then S_FREE, and a
// moving realloc walks in S_ALLOC, then releases the old block in S_FREE. One item at a
// time: the next input beat is taken the cycle after the result beat. Single read port
// sets the walk. Synchronous active-low reset clears counters and control; header memory
// is not cleared. Depends on ilffa_pkg, ilffa_ctrl, ilffa_datapath.
`timescale 1ns / 1ps
module implicit_list_first_fit_allocator import ilffa_pkg::*; #(
    parameter int HEAP_BYTES  = 4096,
    parameter int ALIGN       = 8,
    parameter int MAX_REQUEST = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // func[1:0], req_size[14:2], addr[26:15], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], block_addr[13:2], moved[14],
                                   // payload_in_use[27:15], bytes_laid_out[40:28], fill
);
    logic [12:0] heap_len_reg;
    logic [12:0] req_reg;
    logic [11:0] addr_reg;
    ilffa_cmd_t  cmd;
    ilffa_stat_t stat;
    logic        busy, in_fire, out_fire;
    logic [11:0] cur_addr, res_addr;
    logic [1:0]  res_status;
    logic        res_moved;
    logic [12:0] inuse, used;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign m_tdata  = {7'd0, used, inuse, res_moved, res_addr, res_status};

    always_ff @(posedge aclk) begin
        if (!aresetn) heap_len_reg <= 13'd4096;
        else if (cfg_we) heap_len_reg <= cfg_wdata;
    end
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_reg  <= s_tdata[14:2];
            addr_reg <= s_tdata[26:15];
        end
    end

    ilffa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .func(s_tdata[1:0]),
        .addr(addr_reg), .req_size(req_reg), .out_fire(out_fire), .stat(stat),
        .cur_addr(cur_addr), .cmd(cmd), .busy(busy), .res_valid(m_tvalid),
        .res_status(res_status), .res_addr(res_addr), .res_moved(res_moved)
    );

    ilffa_datapath #(.HEAP_BYTES(HEAP_BYTES), .ALIGN(ALIGN), .MAX_REQUEST(MAX_REQUEST)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .heap_len(heap_len_reg), .req_size(req_reg), .addr(addr_reg),
        .cur_addr(cur_addr), .inuse_out(inuse), .used_out(used)
    );
endmodule

/* verif/tb.sv */
// Self-checking bench for implicit_list_first_fit_allocator: runs a predictor of the heap
// alongside directed and random init/alloc/free/realloc beats on the stream ports.
// Depends on ilffa_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb;
    import ilffa_pkg::*;

    localparam int HEAP_MAX = 4096;
    localparam int HDR      = 8;
    localparam int DEPTH    = HEAP_MAX / HDR;
    localparam int STALL_LIMIT = 20000;   // two full walks plus long stalls, several times over

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // func[1:0], req_size[14:2], addr[26:15], zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // status, block_addr, moved, payload_in_use, bytes_laid_out

    implicit_list_first_fit_allocator u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] block_addr;
        logic        moved;
        logic [12:0] in_use;
        logic [12:0] laid_out;
    } heap_reply_t;

    // Heap shadow: header sizes with the in-use mark in bit 0.
    logic [12:0] hdr_shadow [DEPTH];
    int unsigned n_blocks, laid_bytes, busy_bytes, heap_len;
    bit          tail_open;

    logic [31:0] pending_beats [$];
    heap_reply_t replies_due [$];
    int unsigned live_addrs [$];

    int  errors = 0;
    int  replies_seen = 0;
    int  stall_cycles = 0;
    bit  calm = 1'b0;     // no idling on either side while set
    int  n_alloc = 0, n_free = 0, n_realloc = 0, n_init = 0;

    // First-fit walk; trims the open tail and appends a new free tail when room remains.
    function automatic int unsigned first_fit(int unsigned req);
        int unsigned need, off, sz, rem;
        off = 0;
        if (req == 0 || req > HEAP_MAX) return 0;
        need = (req + 7) & ~32'd7;
        for (int k = 0; k < n_blocks; k++) begin
            sz = hdr_shadow[k] & 13'h1ffe;
            if (!hdr_shadow[k][0] && need <= sz) begin
                if (k == n_blocks - 1 && tail_open) begin
                    rem = sz - need;
                    hdr_shadow[k] = 13'(need | 1);
                    laid_bytes += need;
                    busy_bytes += need;
                    if (rem >= HDR && n_blocks < DEPTH) begin
                        hdr_shadow[n_blocks] = 13'(rem - HDR);
                        n_blocks++;
                        laid_bytes += HDR;
                    end else begin
                        tail_open = 1'b0;
                    end
                end else begin
                    hdr_shadow[k][0] = 1'b1;
                    busy_bytes += sz;
                end
                return off + HDR;
            end
            off += HDR + sz;
        end
        return 0;
    endfunction

    function automatic int block_at(int unsigned addr);
        int unsigned off;
        off = 0;
        for (int k = 0; k < n_blocks; k++) begin
            if (off + HDR == addr) return hdr_shadow[k][0] ? k : -1;
            off += HDR + (hdr_shadow[k] & 13'h1ffe);
        end
        return -1;
    endfunction

    function automatic void release_block(int k);
        hdr_shadow[k][0] = 1'b0;
        busy_bytes -= hdr_shadow[k];
    endfunction

    function automatic heap_reply_t predict(logic [1:0] func, int unsigned req,
                                            int unsigned addr);
        heap_reply_t r;
        int unsigned h;
        int k;
        r = '0;
        case (func)
            FUNC_INIT: begin
                h = heap_len > HEAP_MAX ? HEAP_MAX : heap_len;
                if (h < HDR) begin
                    r.status = ST_FAIL;
                end else begin
                    hdr_shadow[0] = 13'((h - HDR) & ~32'd7);
                    n_blocks = 1;
                    laid_bytes = HDR;
                    busy_bytes = 0;
                    tail_open = 1'b1;
                end
            end
            FUNC_ALLOC: begin
                r.block_addr = 12'(first_fit(req));
                r.status = r.block_addr != 0 ? ST_OK : ST_FAIL;
            end
            FUNC_FREE: begin
                if (addr != 0) begin
                    k = block_at(addr);
                    if (k < 0) r.status = ST_REFUSED;
                    else release_block(k);
                end
            end
            default: begin
                if (addr == 0) begin
                    r.block_addr = 12'(first_fit(req));
                    r.status = r.block_addr != 0 ? ST_OK : ST_FAIL;
                end else begin
                    k = block_at(addr);
                    if (k < 0) begin
                        r.status = ST_REFUSED;
                    end else if (req == 0) begin
                        release_block(k);
                        r.status = ST_FAIL;
                    end else if ((hdr_shadow[k] & 13'h1ffe) >= req) begin
                        r.block_addr = addr[11:0];
                    end else begin
                        r.block_addr = 12'(first_fit(req));
                        if (r.block_addr == 0) begin
                            r.status = ST_FAIL;
                        end else begin
                            release_block(k);
                            r.moved = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.in_use = 13'(busy_bytes);
        r.laid_out = 13'(laid_bytes);
        return r;
    endfunction

    function automatic void drop_live(int unsigned addr);
        foreach (live_addrs[i])
            if (live_addrs[i] == addr) begin
                live_addrs.delete(i);
                return;
            end
    endfunction

    // Queue one beat, predict its reply and keep the list of live blocks current.
    task automatic push_op(logic [1:0] func, int unsigned req, int unsigned addr);
        heap_reply_t r;
        r = predict(func, req, addr);
        pending_beats.push_back({5'b0, addr[11:0], req[12:0], func});
        replies_due.push_back(r);
        case (func)
            FUNC_INIT: begin
                n_init++;
                if (r.status == ST_OK) live_addrs.delete();
            end
            FUNC_ALLOC: begin
                n_alloc++;
                if (r.status == ST_OK) live_addrs.push_back(r.block_addr);
            end
            FUNC_FREE: begin
                n_free++;
                if (addr != 0 && r.status == ST_OK) drop_live(addr);
            end
            default: begin
                n_realloc++;
                if (addr == 0) begin
                    if (r.status == ST_OK) live_addrs.push_back(r.block_addr);
                end else if (r.status == ST_FAIL && req == 0) begin
                    drop_live(addr);
                end else if (r.moved) begin
                    drop_live(addr);
                    live_addrs.push_back(r.block_addr);
                end
            end
        endcase
    endtask

    // Sender holds off until every reply is back; then the block is idle.
    task automatic drain;
        while (pending_beats.size() != 0 || replies_due.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_heap(int unsigned len);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= len[12:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        heap_len = len;
    endtask

    function automatic int unsigned pick_live();
        if (live_addrs.size() == 0) return $urandom_range(4095);
        return live_addrs[$urandom_range(live_addrs.size() - 1)];
    endfunction

    function automatic int unsigned rand_size();
        int p;
        p = $urandom_range(99);
        if (p < 70) return $urandom_range(64, 1);
        if (p < 95) return $urandom_range(512, 65);
        return $urandom_range(4096, 513);
    endfunction

    task automatic random_ops(int n);
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < 45)
                push_op(FUNC_ALLOC, $urandom_range(99) < 3 ? $urandom_range(8191) : rand_size(),
                        $urandom_range(4095));
            else if (p < 75)
                push_op(FUNC_FREE, $urandom_range(8191),
                        $urandom_range(99) < 85 ? pick_live() : $urandom_range(4095));
            else if (p < 98)
                push_op(FUNC_REALLOC, $urandom_range(9) == 0 ? 0 : rand_size(),
                        $urandom_range(99) < 80 ? pick_live()
                        : ($urandom_range(1) ? 0 : $urandom_range(4095)));
            else
                push_op(FUNC_INIT, $urandom_range(8191), $urandom_range(4095));
        end
    endtask

    // Driver: next beat goes out once the current one is taken; random idle cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
                s_tdata <= pending_beats.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side stalls at random too.
    always @(posedge aclk) begin
        m_tready <= aresetn && (calm || $urandom_range(99) >= 30);
    end

    // Monitor: each reply beat against the oldest prediction.
    always @(posedge aclk) begin
        heap_reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.block_addr = m_tdata[13:2];
            got.moved = m_tdata[14];
            got.in_use = m_tdata[27:15];
            got.laid_out = m_tdata[40:28];
            replies_seen++;
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t: reply with none expected: %h", $time, m_tdata);
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                end
                if (got.block_addr !== want.block_addr) begin
                    errors++;
                    $display("%0t: block_addr exp %0d got %0d", $time,
                             want.block_addr, got.block_addr);
                end
                if (got.moved !== want.moved) begin
                    errors++;
                    $display("%0t: moved exp %0d got %0d", $time, want.moved, got.moved);
                end
                if (got.in_use !== want.in_use) begin
                    errors++;
                    $display("%0t: payload_in_use exp %0d got %0d", $time,
                             want.in_use, got.in_use);
                end
                if (got.laid_out !== want.laid_out) begin
                    errors++;
                    $display("%0t: bytes_laid_out exp %0d got %0d", $time,
                             want.laid_out, got.laid_out);
                end
            end
        end
    end

    // Watchdog: cycles with work outstanding but no beat on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_beats.size() == 0 && replies_due.size() == 0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t: no progress, %0d replies outstanding", $time, replies_due.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int unsigned a;
        heap_len = 4096;
        n_blocks = 0;
        laid_bytes = 0;
        busy_bytes = 0;
        tail_open = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Before init: nothing to allocate, nothing to free.
        push_op(FUNC_ALLOC, 8, 0);
        push_op(FUNC_FREE, 0, 8);
        push_op(FUNC_REALLOC, 16, 8);
        // Full heap, directed corners.
        push_op(FUNC_INIT, 0, 0);
        push_op(FUNC_ALLOC, 0, 0);          // zero request
        push_op(FUNC_ALLOC, 4097, 0);       // over the request limit
        push_op(FUNC_ALLOC, 4096, 0);       // larger than the heap payload
        push_op(FUNC_ALLOC, 1, 0);          // rounds to 8 -> payload at 8
        push_op(FUNC_ALLOC, 8, 0);          // payload at 24
        push_op(FUNC_FREE, 0, 0);           // null free
        push_op(FUNC_FREE, 0, 12);          // names no block
        push_op(FUNC_FREE, 0, 8);
        push_op(FUNC_FREE, 0, 8);           // double free refused
        push_op(FUNC_REALLOC, 40, 0);       // null addr acts as allocate
        push_op(FUNC_REALLOC, 4, 24);       // fits, kept in place
        push_op(FUNC_REALLOC, 100, 24);     // grows, moves
        push_op(FUNC_REALLOC, 0, 40);       // to zero bytes frees
        push_op(FUNC_REALLOC, 0, 40);       // now refused
        push_op(FUNC_REALLOC, 16, 4095);    // bad addr
        push_op(FUNC_ALLOC, 3800, 0);       // eats most of the tail; an 88-byte free tail remains
        push_op(FUNC_REALLOC, 4000, 8);     // names a freed block: refused
        push_op(FUNC_ALLOC, 8, 0);          // reuses the freed first block
        set_heap(0);
        push_op(FUNC_INIT, 0, 0);           // short heap
        set_heap(8);
        push_op(FUNC_INIT, 0, 0);           // a single empty block
        push_op(FUNC_ALLOC, 1, 0);
        set_heap(8191);                     // clamped to the heap size
        push_op(FUNC_INIT, 0, 0);
        random_ops(350);

        set_heap(13);                       // unaligned
        push_op(FUNC_INIT, 0, 0);
        random_ops(30);
        set_heap(200);
        push_op(FUNC_INIT, 0, 0);
        random_ops(250);

        set_heap(4096);
        push_op(FUNC_INIT, 0, 0);
        drain();
        calm <= 1'b1;                       // back-to-back stretch
        random_ops(250);
        drain();
        calm <= 1'b0;
        set_heap(1000);
        push_op(FUNC_INIT, 0, 0);
        random_ops(240);
        // exercise high address bits on the free path
        a = 4095;
        push_op(FUNC_FREE, 0, a);

        drain();
        repeat (50) @(posedge aclk);
        $display("Covered %0d init, %0d alloc, %0d free, %0d realloc beats; %0d replies.",
                 n_init, n_alloc, n_free, n_realloc, replies_seen);
        if (errors == 0 && replies_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* sim.f */
design/ilffa_pkg.sv
design/ilffa_datapath.sv
design/ilffa_ctrl.sv
design/implicit_list_first_fit_allocator.sv
verif/tb.sv
